[rtl/core/assert_macros.svh]
// Assertion macros used by the top-level cache model for its checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition a at a clock edge implies condition c at the same edge.
`define ASSERT_SAME(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("cache control check failed");

// Condition a at a clock edge implies condition c at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("cache sequencing check failed");

`endif

[rtl/core/sac_pkg.sv]
// Package with the shared types and constants of the set-associative cache model.
package sac_pkg;

    localparam int MAX_SETS   = 64;
    localparam int MAX_WAYS   = 8;
    localparam int COUNT_BITS = 32;

    localparam int ADDR_W  = 64;
    localparam int SET_W   = 6;
    localparam int WAY_W   = 3;
    localparam int FILL_W  = 4;
    localparam int RANK_W  = 3;
    localparam int TOTAL_W = 32;

    localparam int SIB_W  = 3;
    localparam int OFS_W  = 6;
    localparam int WAYS_W = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS        = 2'd2;

    localparam logic [1:0] OUT_HIT   = 2'd0;
    localparam logic [1:0] OUT_MISS  = 2'd1;
    localparam logic [1:0] OUT_EVICT = 2'd2;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    typedef logic [COUNT_BITS-1:0] count_t;

    // One row of the set store: all tags, age ranks and the fill count of a set.
    typedef struct packed {
        logic [MAX_WAYS-1:0][ADDR_W-1:0] tags;
        logic [MAX_WAYS-1:0][RANK_W-1:0] ranks;
        logic [FILL_W-1:0]               fill;
    } set_row_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic commit;
    } sac_cmd_t;

endpackage

[rtl/core/sac_ifs.sv]
// Valid/ready channel interfaces for cache accesses and cache results.
interface sac_acc_if
    import sac_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] addr;
    logic              is_modify;

    modport source (output valid, output addr, output is_modify, input ready);
    modport sink (input valid, input addr, input is_modify, output ready);
endinterface

interface sac_res_if
    import sac_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [1:0]         outcome;
    logic               extra_hit;
    logic [TOTAL_W-1:0] hit_total;
    logic [TOTAL_W-1:0] miss_total;
    logic [TOTAL_W-1:0] evict_total;

    modport source (output valid, output outcome, output extra_hit, output hit_total,
                    output miss_total, output evict_total, input ready);
    modport sink (input valid, input outcome, input extra_hit, input hit_total,
                  input miss_total, input evict_total, output ready);
endinterface

[rtl/core/sac_ctrl.sv]
// Controller state machine that sequences the lookup and update of each access.
module sac_ctrl
    import sac_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output sac_cmd_t cmd
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_UPDATE = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;

    always_comb
    begin
        in_ready       = (state_reg == ST_IDLE);
        cmd.capture    = 1'b0;
        cmd.commit     = 1'b0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                // The result register must be free or emptying this cycle.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[rtl/core/sac_dp.sv]
// Datapath with the configuration, set store, way compare, LRU update and counters.
module sac_dp
    import sac_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [ADDR_W-1:0]     in_addr,
    input  logic                  in_is_modify,
    input  sac_cmd_t              cmd,
    output logic [1:0]            out_outcome,
    output logic                  out_extra_hit,
    output logic [TOTAL_W-1:0]    out_hit_total,
    output logic [TOTAL_W-1:0]    out_miss_total,
    output logic [TOTAL_W-1:0]    out_evict_total
);

    // Configuration registers.
    logic [SIB_W-1:0]  sib_reg;
    logic [OFS_W-1:0]  ofs_reg;
    logic [WAYS_W-1:0] ways_reg;

    // Set store and per-row valid bits; an invalid row reads as empty.
    set_row_t          set_mem [MAX_SETS];
    logic [MAX_SETS-1:0] row_valid_reg;

    // Captured access.
    logic [SET_W-1:0]  set_reg;
    logic [ADDR_W-1:0] tag_reg;
    logic              mod_reg;
    set_row_t          row_reg;
    logic              rv_reg;

    count_t hits_reg;
    count_t misses_reg;
    count_t evicts_reg;

    logic [1:0]         outcome_reg;
    logic               extra_reg;
    logic [TOTAL_W-1:0] hit_out_reg;
    logic [TOTAL_W-1:0] miss_out_reg;
    logic [TOTAL_W-1:0] evict_out_reg;

    // Address split.
    logic [ADDR_W-1:0] shifted;
    logic [SIB_W+3:0]  sel_mask;
    logic [SET_W-1:0]  set_in;
    logic [OFS_W:0]    tshift;
    logic [ADDR_W-1:0] tag_in;

    // Lookup and update.
    logic [FILL_W-1:0]               fill_raw;
    logic [FILL_W-1:0]               fill_eff;
    logic [FILL_W-1:0]               ways_eff;
    logic [MAX_WAYS-1:0][RANK_W-1:0] ranks;
    logic                            found;
    logic [WAY_W-1:0]                hit_way;
    logic [WAY_W-1:0]                victim;
    logic                            has_free;
    logic [WAY_W-1:0]                sel_way;
    logic [FILL_W-1:0]               old_rank;
    logic [1:0]                      outcome;
    set_row_t                        new_row;
    logic [1:0]                      hit_inc;
    count_t                          hits_next;
    count_t                          misses_next;
    count_t                          evicts_next;

    function automatic count_t sat_add(input count_t cnt, input logic [1:0] inc);
        logic [COUNT_BITS:0] sum;
        sum = {1'b0, cnt} + (COUNT_BITS + 1)'(inc);
        return (sum > {1'b0, CNT_MAX}) ? CNT_MAX : sum[COUNT_BITS-1:0];
    endfunction

    always_comb
    begin
        shifted  = in_addr >> ofs_reg;
        sel_mask = ((SIB_W + 4)'(1) << sib_reg) - (SIB_W + 4)'(1);
        set_in   = shifted[SET_W-1:0] & sel_mask[SET_W-1:0];
        tshift   = (OFS_W + 1)'(sib_reg) + (OFS_W + 1)'(ofs_reg);
        tag_in   = (tshift >= (OFS_W + 1)'(ADDR_W)) ? '0 : (in_addr >> tshift);
    end

    always_comb
    begin
        fill_raw = rv_reg ? row_reg.fill : '0;
        fill_eff = (fill_raw > FILL_W'(MAX_WAYS)) ? FILL_W'(MAX_WAYS) : fill_raw;
        if (ways_reg == '0)
            ways_eff = FILL_W'(1);
        else if (ways_reg > WAYS_W'(MAX_WAYS))
            ways_eff = FILL_W'(MAX_WAYS);
        else
            ways_eff = FILL_W'(ways_reg);
        ranks = rv_reg ? row_reg.ranks : '0;

        // First filled way whose tag matches.
        found   = 1'b0;
        hit_way = '0;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (!found && (FILL_W'(i) < fill_eff) && (row_reg.tags[i] == tag_reg))
            begin
                found   = 1'b1;
                hit_way = WAY_W'(i);
            end
        end

        // Oldest filled way, lowest index on a tie.
        victim = '0;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if ((FILL_W'(i) < fill_eff) && (ranks[i] > ranks[victim]))
                victim = WAY_W'(i);
        end

        has_free = (fill_eff < ways_eff);
        if (found)
        begin
            sel_way  = hit_way;
            old_rank = {1'b0, ranks[hit_way]};
            outcome  = OUT_HIT;
        end
        else if (has_free)
        begin
            sel_way  = fill_eff[WAY_W-1:0];
            old_rank = fill_eff;
            outcome  = OUT_MISS;
        end
        else
        begin
            sel_way  = victim;
            old_rank = {1'b0, ranks[victim]};
            outcome  = OUT_EVICT;
        end

        new_row      = row_reg;
        new_row.fill = (!found && has_free) ? (fill_eff + FILL_W'(1)) : fill_raw;
        if (!found)
            new_row.tags[sel_way] = tag_reg;
        // The chosen way becomes most recent; every filled way younger than it ages.
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (WAY_W'(i) == sel_way)
                new_row.ranks[i] = '0;
            else if ((FILL_W'(i) < fill_eff) && ({1'b0, ranks[i]} < old_rank))
                new_row.ranks[i] = ranks[i] + RANK_W'(1);
            else
                new_row.ranks[i] = ranks[i];
        end

        hit_inc     = {1'b0, found} + {1'b0, mod_reg};
        hits_next   = sat_add(hits_reg, hit_inc);
        misses_next = sat_add(misses_reg, {1'b0, !found});
        evicts_next = sat_add(evicts_reg, {1'b0, (outcome == OUT_EVICT)});
    end

    // Control state: configuration, row valid bits and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sib_reg       <= '0;
            ofs_reg       <= '0;
            ways_reg      <= WAYS_W'(1);
            row_valid_reg <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            evicts_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SET_BITS:    sib_reg  <= cfg_wdata[SIB_W-1:0];
                    CFG_OFFSET_BITS: ofs_reg  <= cfg_wdata[OFS_W-1:0];
                    CFG_WAYS:        ways_reg <= cfg_wdata[WAYS_W-1:0];
                    default:         ;
                endcase
            end
            if (cmd.commit)
            begin
                row_valid_reg[set_reg] <= 1'b1;
                hits_reg               <= hits_next;
                misses_reg             <= misses_next;
                evicts_reg             <= evicts_next;
            end
        end
    end

    // Set store: read at capture, written back at commit.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            row_reg <= set_mem[set_in];
        if (cmd.commit)
            set_mem[set_reg] <= new_row;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            set_reg <= set_in;
            tag_reg <= tag_in;
            mod_reg <= in_is_modify;
            rv_reg  <= row_valid_reg[set_in];
        end
        if (cmd.commit)
        begin
            outcome_reg   <= outcome;
            extra_reg     <= mod_reg;
            hit_out_reg   <= TOTAL_W'(hits_next);
            miss_out_reg  <= TOTAL_W'(misses_next);
            evict_out_reg <= TOTAL_W'(evicts_next);
        end
    end

    assign out_outcome     = outcome_reg;
    assign out_extra_hit   = extra_reg;
    assign out_hit_total   = hit_out_reg;
    assign out_miss_total  = miss_out_reg;
    assign out_evict_total = evict_out_reg;

endmodule

[rtl/core/set_assoc_lru_cache_model.sv]
// Top level of the set-associative cache hit/miss model with true LRU replacement.
//
//   Channel | Direction | Payload                                          | Handshake
//   --------+-----------+--------------------------------------------------+-------------
//   acc     | in        | addr, is_modify                                  | valid/ready
//   res     | out       | outcome, extra_hit, hit_total, miss_total,       | valid/ready
//           |           | evict_total                                      |
//   cfg     | in        | cfg_index, cfg_wdata                             | cfg_we only
//
// For each item, at the accepting edge the set row (all tags, age ranks and
// fill count) is read from the set store, and in the update state the ways
// are compared, the LRU order is updated and the row is written back.
// The single set-store port carries one read and one write per item.
// Reset clears the row valid bits at once, so there is no clearing pass; a row
// never written reads as an empty set.
// The result sits in an output register; a new item is accepted while it waits,
// and the update cycle holds only while that register is still full.
`include "assert_macros.svh"

module set_assoc_lru_cache_model
    import sac_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    sac_acc_if.sink               acc,
    sac_res_if.source             res
);

    sac_cmd_t cmd;

    // The controller owns the handshakes and decides when to read and commit.
    sac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (acc.valid),
        .in_ready  (acc.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .cmd       (cmd)
    );

    // The datapath holds the configuration, the set store and the counters.
    sac_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .in_addr         (acc.addr),
        .in_is_modify    (acc.is_modify),
        .cmd             (cmd),
        .out_outcome     (res.outcome),
        .out_extra_hit   (res.extra_hit),
        .out_hit_total   (res.hit_total),
        .out_miss_total  (res.miss_total),
        .out_evict_total (res.evict_total)
    );

    // A captured item blocks the input until its update has committed.
    `ASSERT_NEXT(a_one_in_flight, clk, rst_n, cmd.capture, !acc.ready)
    // A commit always leaves a result waiting at the output.
    `ASSERT_NEXT(a_commit_shows_result, clk, rst_n, cmd.commit, res.valid)
    // Reading a new row and writing back an old one never share a cycle.
    `ASSERT_SAME(a_no_capture_on_commit, clk, rst_n, cmd.commit, !cmd.capture)

endmodule
